// ----- sv/dark_channel_min_filter_macros.svh -----
// Assertion macros for the dark channel minimum filter checker.
// Depends on: nothing; the user supplies clk and rst_n in scope.
`ifndef DARK_CHANNEL_MIN_FILTER_MACROS_SVH
`define DARK_CHANNEL_MIN_FILTER_MACROS_SVH
// same-cycle implication, disabled in reset
`define DCMF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcmf assertion failed");
// next-cycle implication, disabled in reset
`define DCMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcmf assertion failed");
`endif

// ----- sv/dcmf_pkg.sv -----
// Shared constants, types and helpers of the dark channel minimum filter.
// Depends on: nothing.
package dcmf_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_BOX    = 15;
  localparam int MAX_HEIGHT = 2048;
  localparam int STORE_SIZE = MAX_BOX * MAX_WIDTH;
  localparam int ADDR_W     = 15;
  localparam int LIN_W      = 23;
  localparam int CMP_W      = 24;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int DIM_W      = 12;
  localparam int BOX_W      = 4;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 12;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef enum logic [1:0] {
    REG_BOX_SIZE    = 2'd0,
    REG_IMAGE_WIDTH = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_INV_AIRLIGHT = 2'd3
  } reg_idx_t;

  // tag that travels with each line store read
  typedef struct packed {
    logic             v;
    logic             pad;
    logic             eor;
    logic             last;
    logic [LIN_W-1:0] lin;
  } rd_tag_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y);
    min2 = (x < y) ? x : y;
  endfunction

  // linear pixel index modulo 15*2048: 2048*q mod 30720 = 2048*(q mod 15),
  // q mod 15 by hex digit sum
  function automatic logic [ADDR_W-1:0] store_addr(input logic [LIN_W-1:0] lin);
    logic [5:0] s;
    logic [4:0] t;
    s = 6'(lin[14:11]) + 6'(lin[18:15]) + 6'(lin[22:19]);
    t = 5'(s[3:0]) + 5'(s[5:4]);
    if (t >= 5'd15) t = t - 5'd15;
    store_addr = {t[3:0], lin[10:0]};
  endfunction
endpackage

// ----- sv/dcmf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on: nothing.
module dcmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/dcmf_cell.sv -----
// One cell of the running-minimum chain: holds min of broadcast sample and
// the neighbor's minimum. Depends on: dcmf_pkg.
module dcmf_cell import dcmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [PIX_W-1:0] x,
  input  logic [PIX_W-1:0] m_in,
  output logic [PIX_W-1:0] m_out
);
  logic [PIX_W-1:0] m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= PIX_MAX;
    end else if (en) begin
      m_r <= min2(x, m_in);
    end
  end

  assign m_out = m_r;
endmodule

// ----- sv/dark_channel_min_filter.sv -----
// Dark channel minimum filter top level: sequencer, line store, cell chain.
// Depends on: dcmf_pkg, dcmf_ram, dcmf_cell.
//
//  port group | dir     | handshake          | content
//  in_*       | in      | in_valid/in_ready  | kind, red, green, blue
//  out_*      | out     | out_valid/out_ready| dark_value, row, col, last_of_frame
//  cfg_*      | in      | cfg_we only        | register index, write data
//
// An item that gives no result passes through IDLE, CHK, MUL, WR, N and DEC. An
// item with a result then sweeps the line store, 15 entries for each of the R rows
// of the clipped box (R up to 15), one entry per cycle through its single read port.
// Reset is synchronous active low; the line store holds no reset.
// A result waits in the output register; the next item is taken meanwhile,
// and only a second result stalls the sequencer until the first is taken.
module dark_channel_min_filter import dcmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [PIX_W-1:0]  in_red,
  input  logic [PIX_W-1:0]  in_green,
  input  logic [PIX_W-1:0]  in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_dark_value,
  output logic [COL_W-1:0]  out_row,
  output logic [COL_W-1:0]  out_col,
  output logic              out_last_of_frame,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_wdata
);
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHK   = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_WR    = 9'b000001000,
    ST_N     = 9'b000010000,
    ST_DEC   = 9'b000100000,
    ST_SWEEP = 9'b001000000,
    ST_DRAIN = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  // configuration
  logic [BOX_W-1:0]  box_r;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r    <= BOX_W'(15);
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      gain_r   <= GAIN_W'(4096);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BOX_SIZE:     box_r    <= cfg_wdata[BOX_W-1:0];
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_INV_AIRLIGHT: gain_r   <= cfg_wdata;
        default:          gain_r   <= gain_r;
      endcase
    end
  end

  // effective frame and box dimensions
  logic [DIM_W-1:0] w, h;
  logic [BOX_W-1:0] k, a, b;
  assign w = (width_r == '0) ? DIM_W'(1) :
             (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h = (height_r == '0) ? DIM_W'(1) :
             (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;
  assign k = (box_r == '0) ? BOX_W'(1) : box_r;
  assign a = k >> 1;
  assign b = k - BOX_W'(1) - a;

  // sequencer state
  state_t            state_r, state_nxt;
  logic              kind_r;
  logic [PIX_W-1:0]  dmin_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r, emit_row_r, emit_col_r;
  logic              complete_r;
  logic [LIN_W-1:0]  mul_r;
  logic [CMP_W-1:0]  n_r, p_r, lag_r;
  logic [COL_W-1:0]  r1_r, c0_r, c1_r, sr_r;
  logic [BOX_W-1:0]  ci_r;
  logic [PIX_W-1:0]  acc_r;
  logic              out_valid_r, out_last_r;
  logic [OUT_W-1:0]  out_dark_r;
  logic [COL_W-1:0]  out_row_r, out_col_r;
  rd_tag_t           t1_r, t2_r, t3_r;

  // line store
  logic              st_we;
  logic [PIX_W-1:0]  st_rdata;

  assign st_we = (state_r == ST_WR) && !kind_r && !complete_r;

  dcmf_ram #(.WIDTH(PIX_W), .DEPTH(STORE_SIZE)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (store_addr(mul_r)),
    .wdata (dmin_r),
    .raddr (store_addr(t1_r.lin)),
    .rdata (st_rdata)
  );

  // running-minimum chain: last cell gives min of the last MAX_BOX samples
  logic [PIX_W-1:0] chain_m [MAX_BOX];
  logic [PIX_W-1:0] chain_x;
  assign chain_x = t2_r.pad ? PIX_MAX : st_rdata;

  for (genvar j = 0; j < MAX_BOX; j++) begin : g_chain
    dcmf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (t2_r.v),
      .x     (chain_x),
      .m_in  ((j == 0) ? PIX_MAX : chain_m[(j == 0) ? 0 : j-1]),
      .m_out (chain_m[j])
    );
  end

  // box bounds and sweep helpers
  logic [ROW_W-1:0]  er_b, ec_b;
  logic [COL_W-1:0]  r0_c, r1_c, c0_c, c1_c;
  logic [ROW_W-1:0]  col_c;
  logic              eor_c;
  assign er_b = ROW_W'(emit_row_r) + ROW_W'(b);
  assign ec_b = ROW_W'(emit_col_r) + ROW_W'(b);
  assign r0_c = (emit_row_r > COL_W'(a)) ? emit_row_r - COL_W'(a) : '0;
  assign c0_c = (emit_col_r > COL_W'(a)) ? emit_col_r - COL_W'(a) : '0;
  assign r1_c = (er_b < h) ? er_b[COL_W-1:0] : COL_W'(h - DIM_W'(1));
  assign c1_c = (ec_b < w) ? ec_b[COL_W-1:0] : COL_W'(w - DIM_W'(1));
  assign col_c = ROW_W'(c0_r) + ROW_W'(ci_r);
  assign eor_c = (ci_r == BOX_W'(MAX_BOX - 1));

  // write-side counter advance
  logic [ROW_W-1:0] in_col_inc;
  assign in_col_inc = ROW_W'(in_col_r) + ROW_W'(1);

  // output scaling: Q4.12 gain, round half up, saturate
  logic [24:0] prod_c;
  logic [OUT_W-1:0] scaled_c;
  assign prod_c   = 25'(acc_r) * 25'(gain_r) + 25'(2048);
  assign scaled_c = (prod_c[24:12] > 13'(4095)) ? OUT_W'(4095) : prod_c[23:12];

  // emit counter advance
  logic [ROW_W-1:0] ec_inc, er_inc;
  logic             out_free;
  assign ec_inc   = ROW_W'(emit_col_r) + ROW_W'(1);
  assign er_inc   = ROW_W'(emit_row_r) + ROW_W'(1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHK;
      ST_CHK:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_N;
      ST_N:     state_nxt = ST_DEC;
      ST_DEC:   state_nxt = (complete_r || n_r >= p_r + lag_r + CMP_W'(1)) ?
                            ST_SWEEP : ST_IDLE;
      ST_SWEEP: if (eor_c && sr_r == r1_r) state_nxt = ST_DRAIN;
      ST_DRAIN: if (t3_r.v && t3_r.last) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_row_r    <= '0;
      in_col_r    <= '0;
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
      t1_r.v      <= 1'b0;
      t2_r.v      <= 1'b0;
      t3_r.v      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t2_r    <= t1_r;
      t3_r    <= t2_r;
      t1_r.v  <= (state_r == ST_SWEEP);
      // a new result may load in the cycle the old one leaves
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_CHK: begin
          // counters left outside a changed frame start over
          if (ROW_W'(in_col_r) >= w || ROW_W'(emit_col_r) >= w ||
              ROW_W'(emit_row_r) >= h || in_row_r > h) begin
            in_row_r   <= '0;
            in_col_r   <= '0;
            emit_row_r <= '0;
            emit_col_r <= '0;
          end
        end
        ST_MUL: complete_r <= (in_row_r >= h);
        ST_WR: begin
          if (!kind_r && !complete_r) begin
            if (in_col_inc >= w) begin
              in_col_r   <= '0;
              in_row_r   <= in_row_r + ROW_W'(1);
              complete_r <= (in_row_r + ROW_W'(1) >= h);
            end else begin
              in_col_r <= in_col_inc[COL_W-1:0];
            end
          end
        end
        ST_SWEEP: begin
          t1_r.lin  <= LIN_W'(sr_r) * LIN_W'(w) + LIN_W'(col_c);
          t1_r.pad  <= col_c > ROW_W'(c1_r);
          t1_r.eor  <= eor_c;
          t1_r.last <= eor_c && (sr_r == r1_r);
        end
        ST_OUT: begin
          if (out_free) begin
            out_last_r <= (ec_inc >= w) && (er_inc >= h);
            if (ec_inc >= w && er_inc >= h) begin
              // frame done: all row and column counters start over
              in_row_r   <= '0;
              in_col_r   <= '0;
              emit_row_r <= '0;
              emit_col_r <= '0;
            end else if (ec_inc >= w) begin
              emit_col_r <= '0;
              emit_row_r <= er_inc[COL_W-1:0];
            end else begin
              emit_col_r <= ec_inc[COL_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      kind_r <= in_kind;
      dmin_r <= min2(in_red, min2(in_green, in_blue));
    end
    if (state_r == ST_MUL)
      mul_r <= LIN_W'(in_row_r[COL_W-1:0]) * LIN_W'(w) + LIN_W'(in_col_r);
    if (state_r == ST_N) begin
      n_r   <= complete_r ? CMP_W'(w) * CMP_W'(h) :
               CMP_W'(in_row_r[COL_W-1:0]) * CMP_W'(w) + CMP_W'(in_col_r);
      p_r   <= CMP_W'(emit_row_r) * CMP_W'(w) + CMP_W'(emit_col_r);
      lag_r <= CMP_W'(b) * CMP_W'(w) + CMP_W'(b);
    end
    if (state_r == ST_DEC) begin
      sr_r  <= r0_c;
      r1_r  <= r1_c;
      c0_r  <= c0_c;
      c1_r  <= c1_c;
      ci_r  <= '0;
      acc_r <= PIX_MAX;
    end
    if (state_r == ST_SWEEP) begin
      if (eor_c) begin
        ci_r <= '0;
        sr_r <= sr_r + COL_W'(1);
      end else begin
        ci_r <= ci_r + BOX_W'(1);
      end
    end
    // one full row of samples has passed the chain
    if (t3_r.v && t3_r.eor) acc_r <= min2(acc_r, chain_m[MAX_BOX-1]);
    if (state_r == ST_OUT && out_free) begin
      out_dark_r <= scaled_c;
      out_row_r  <= emit_row_r;
      out_col_r  <= emit_col_r;
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_dark_value    = out_dark_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_frame = out_last_r;
endmodule

// ----- sv/dark_channel_min_filter_checker.sv -----
// Port-level checker for the dark channel minimum filter, bound to the top.
// Depends on: dcmf_pkg, dark_channel_min_filter_macros.svh.
`include "dark_channel_min_filter_macros.svh"
module dark_channel_min_filter_checker import dcmf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [OUT_W-1:0]  out_dark_value,
  input logic [COL_W-1:0]  out_row,
  input logic [COL_W-1:0]  out_col,
  input logic              out_last_of_frame
);
  // a stalled result holds
  `DCMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_dark_value) && $stable(out_row) && $stable(out_col) && $stable(out_last_of_frame))
  // one item in work at a time
  `DCMF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // a new result only comes out of the working sequencer
  `DCMF_ASSERT_NOW(a_out_from_work, $rose(out_valid), !$past(in_ready))
endmodule

bind dark_channel_min_filter dark_channel_min_filter_checker u_checker (.*);
